// ----- hw/rtl/ahdp_pkg.sv -----
// ----------------------------------------------------------------------------
// ahdp_pkg: shared types for the ASCII hex/decimal value parser
// Error codes, the classified character entry and the queue status group.
// ----------------------------------------------------------------------------
package ahdp_pkg;

   localparam int DataWidth = 32;

   typedef enum logic [2:0] {
      ERR_OK         = 3'd0,
      ERR_EMPTY      = 3'd1,
      ERR_NOT_NUMBER = 3'd2,
      ERR_TOO_LARGE  = 3'd3,
      ERR_TOO_SMALL  = 3'd4
   } err_code_type;

   // One classified request as it travels from front to back
   typedef struct packed {
      logic       has_char;
      logic       last;
      logic       is_dec;      // '0'..'9'
      logic       is_hex_ltr;  // 'A'..'F' or 'a'..'f'
      logic       is_x;        // 'x' or 'X'
      logic [3:0] digit;       // digit value when is_dec or is_hex_ltr
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hw/rtl/ahdp_front.sv -----
// ----------------------------------------------------------------------------
// ahdp_front: request intake and character classifier
// Accepts requests, decodes the character class and digit value, and pushes
// the entry into the queue. A request with no character and no last mark
// is accepted and dropped.
// ----------------------------------------------------------------------------
module ahdp_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_ch,
   input  logic                  req_has_char,
   input  logic                  req_last,
   input  ahdp_pkg::q_status_type q_stat,
   output logic                  push,
   output ahdp_pkg::entry_type   push_entry
);
   import ahdp_pkg::*;

   logic is_upper;
   logic is_lower;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full && (req_has_char || req_last);

   assign is_upper = (req_ch >= 8'h41) && (req_ch <= 8'h46);
   assign is_lower = (req_ch >= 8'h61) && (req_ch <= 8'h66);

   always_comb begin
      push_entry.has_char   = req_has_char;
      push_entry.last       = req_last;
      push_entry.is_dec     = (req_ch >= 8'h30) && (req_ch <= 8'h39);
      push_entry.is_hex_ltr = is_upper || is_lower;
      push_entry.is_x       = (req_ch == 8'h78) || (req_ch == 8'h58);
      // letters A-F / a-f have low nibble 1..6: add 9 to get 10..15
      if (push_entry.is_dec) begin
         push_entry.digit = req_ch[3:0];
      end else begin
         push_entry.digit = req_ch[3:0] + 4'd9;
      end
   end

endmodule

// ----- hw/rtl/ahdp_queue.sv -----
// ----------------------------------------------------------------------------
// ahdp_queue: small FIFO between intake and evaluation
// Holds classified entries so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ahdp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ahdp_pkg::entry_type    push_entry,
   input  logic                   pop,
   output ahdp_pkg::entry_type    head,
   output ahdp_pkg::q_status_type q_stat
);
   import ahdp_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   entry_type             mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign q_stat.full  = (count_ff == CntWidth'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/ahdp_back.sv -----
// ----------------------------------------------------------------------------
// ahdp_back: accumulator, prefix tracking and range check
// Consumes one entry per cycle unless the response stalls, folds the digit
// into the value and, on the last entry, registers value and error code.
// ----------------------------------------------------------------------------
module ahdp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ahdp_pkg::entry_type    head,
   input  ahdp_pkg::q_status_type q_stat,
   output logic                   pop,
   input  logic [31:0]            min_value,
   input  logic [31:0]            max_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_value,
   output logic [2:0]             rsp_error_code,
   output logic                   rsp_ok
);
   import ahdp_pkg::*;

   localparam logic [1:0] POS_NONE = 2'd0;
   localparam logic [1:0] POS_ONE  = 2'd1;
   localparam logic [1:0] POS_MANY = 2'd2;

   logic [DataWidth-1:0] acc_ff, acc_in;
   logic [1:0]           pos_ff, pos_in;
   logic                 hex_ff, hex_in;
   logic                 bad_ff, bad_in;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   err_code_type         rsp_code_ff, rsp_code_in;

   logic                 try_add;
   logic                 use_hex;
   logic                 legal;

   // a last entry needs the response register free or draining
   assign pop = !q_stat.empty && (!head.last || !rsp_valid_ff || rsp_ready);

   always_comb begin
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      hex_in  = hex_ff;
      bad_in  = bad_ff;
      try_add = 1'b0;
      use_hex = 1'b0;
      legal   = 1'b0;
      if (head.has_char) begin
         case (pos_ff)
            POS_NONE: begin
               try_add = 1'b1;
               pos_in  = POS_ONE;
            end
            POS_ONE: begin
               if (hex_ff) begin
                  try_add = 1'b1;
                  use_hex = 1'b1;
                  pos_in  = POS_MANY;
               end else if (!bad_ff && (acc_ff == '0) && head.is_x) begin
                  hex_in = 1'b1;
               end else begin
                  try_add = 1'b1;
                  pos_in  = POS_MANY;
               end
            end
            default: begin
               try_add = 1'b1;
               use_hex = hex_ff;
            end
         endcase
      end
      if (try_add && !bad_ff) begin
         legal = head.is_dec || (use_hex && head.is_hex_ltr);
         if (!legal) begin
            bad_in = 1'b1;
         end else if (use_hex) begin
            acc_in = {acc_ff[DataWidth-5:0], 4'b0000} + {28'd0, head.digit};
         end else begin
            // times ten as x*8 + x*2, wrapping at 32 bits
            acc_in = {acc_ff[DataWidth-4:0], 3'b000} + {acc_ff[DataWidth-2:0], 1'b0}
                   + {28'd0, head.digit};
         end
      end
   end

   always_comb begin
      rsp_value_in = acc_in;
      if (pos_in == POS_NONE) begin
         rsp_code_in  = ERR_EMPTY;
         rsp_value_in = '0;
      end else if (bad_in || (hex_in && (pos_in == POS_ONE))) begin
         rsp_code_in = ERR_NOT_NUMBER;
      end else if (acc_in < min_value) begin
         rsp_code_in = ERR_TOO_SMALL;
      end else if (acc_in > max_value) begin
         rsp_code_in = ERR_TOO_LARGE;
      end else begin
         rsp_code_in = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= POS_NONE;
         hex_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (head.last) begin
               acc_ff <= '0;
               pos_ff <= POS_NONE;
               hex_ff <= 1'b0;
               bad_ff <= 1'b0;
            end else begin
               acc_ff <= acc_in;
               pos_ff <= pos_in;
               hex_ff <= hex_in;
               bad_ff <= bad_in;
            end
         end
         if (pop && head.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last) begin
         rsp_value_ff <= rsp_value_in;
         rsp_code_ff  <= rsp_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_error_code = rsp_code_ff;
   assign rsp_ok         = (rsp_code_ff == ERR_OK);

endmodule

// ----- hw/rtl/ascii_hex_dec_value_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_hex_dec_value_parser: ASCII decimal / 0x-hex string to 32-bit value
// A last request's entry is first written into the queue, then evaluated and
// loaded into the response register, which drives rsp_valid.
// Throughput: one request per cycle while the queue is not full; the
// shift-and-add stage keeps pace, and the queue absorbs response stalls.
// Reset: synchronous; clears queue, parser state, response valid, and loads
// min_value 0 and max_value all ones.
// ----------------------------------------------------------------------------
module ascii_hex_dec_value_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_has_char,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_ok,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ahdp_pkg::*;

   localparam logic REG_MIN = 1'b0;
   localparam logic REG_MAX = 1'b1;

   logic [31:0]  min_ff;
   logic [31:0]  max_ff;
   logic         csr_wr;
   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head;
   q_status_type q_stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_MAX) ? max_ff : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '1;
      end else if (csr_wr) begin
         if (paddr[2] == REG_MIN) begin
            min_ff <= pwdata;
         end else begin
            max_ff <= pwdata;
         end
      end
   end

   ahdp_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .req_has_char (req_has_char),
      .req_last     (req_last),
      .q_stat       (q_stat),
      .push         (push),
      .push_entry   (push_entry)
   );

   ahdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   ahdp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_stat         (q_stat),
      .pop            (pop),
      .min_value      (min_ff),
      .max_value      (max_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code),
      .rsp_ok         (rsp_ok)
   );

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ok == (rsp_error_code == ERR_OK)))
      else $error("rsp_ok disagrees with rsp_error_code");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> rsp_valid)
      else $error("last request consumed without a response");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code == ERR_EMPTY)) |-> (rsp_value == '0))
      else $error("empty string response carries a nonzero value");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("evaluation stage consumed from an empty queue");

endmodule
